// ----- rtl/sieac_pkg.sv -----
// Package: shared types, codes and constants of the sparse integer arithmetic core.
`default_nettype none
package sieac_pkg;

   localparam int OFFSET_W = 31;
   localparam int VALUE_W  = 32;
   localparam int MAG_W    = 31;
   localparam int STEPS    = 31;
   localparam int STEP_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   localparam logic [VALUE_W-1:0] NA_VALUE = 32'h8000_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARSE_ON_LEFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NA_BACKGROUND  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNAR_MODE   = 2'd3;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_MOD = 3'd3,
      OP_DIV = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]       element_offset;
      logic signed [VALUE_W-1:0] sparse_value;
      logic signed [VALUE_W-1:0] dense_value;
      logic                      last_entry;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]       result_offset;
      logic signed [VALUE_W-1:0] result_value;
      logic [OFFSET_W-1:0]       output_position;
      logic                      kept;
      logic                      end_of_vector;
      logic                      overflow_seen;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic divide;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
   } unit_stat_type;

endpackage
`default_nettype wire

// ----- rtl/sieac_shift_unit.sv -----
// Shared bit-serial unit: shift-add multiply and restoring divide on magnitudes.
`default_nettype none
module sieac_shift_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  sieac_pkg::unit_ctl_type      ctl,
   input  logic [sieac_pkg::MAG_W-1:0]  mag_a,
   input  logic [sieac_pkg::MAG_W-1:0]  mag_b,
   output sieac_pkg::unit_stat_type     stat,
   output logic [sieac_pkg::VALUE_W-1:0] hi,
   output logic [sieac_pkg::MAG_W-1:0]  lo
);
   import sieac_pkg::*;

   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               div_ff, div_in;
   logic [VALUE_W-1:0] hi_ff, hi_in;
   logic [MAG_W-1:0]   lo_ff, lo_in;
   logic [VALUE_W-1:0] m_ff, m_in;

   logic [VALUE_W-1:0] shifted;
   logic [VALUE_W-1:0] opa;
   logic [VALUE_W-1:0] opb;
   logic [VALUE_W:0]   sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      m_ff   <= m_in;
   end

   // one adder: divide subtracts the divisor, multiply adds the multiplicand
   always_comb begin
      shifted = {hi_ff[VALUE_W-2:0], lo_ff[MAG_W-1]};
      opa     = div_ff ? shifted : hi_ff;
      opb     = div_ff ? ~m_ff : (lo_ff[0] ? m_ff : '0);
      sum     = {1'b0, opa} + {1'b0, opb} + {{VALUE_W{1'b0}}, div_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      m_in    = m_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = ctl.divide;
         hi_in   = '0;
         lo_in   = mag_a;
         m_in    = {1'b0, mag_b};
      end else if (busy_ff) begin
         if (div_ff) begin
            if (sum[VALUE_W]) begin
               hi_in = sum[VALUE_W-1:0];
               lo_in = {lo_ff[MAG_W-2:0], 1'b1};
            end else begin
               hi_in = shifted;
               lo_in = {lo_ff[MAG_W-2:0], 1'b0};
            end
         end else begin
            hi_in = sum[VALUE_W:1];
            lo_in = {sum[0], lo_ff[MAG_W-1:1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign hi        = hi_ff;
   assign lo        = lo_ff;

endmodule
`default_nettype wire

// ----- rtl/sparse_int_elementwise_arith_core.sv -----
// Top level: sparse integer element-wise arithmetic core with sequencer and result register.
// Add, subtract, unused codes: accept moves the sequencer to done, where the result is loaded.
// Multiply, modulo, division: accept loads the shared bit-serial shift unit, which runs its 31 steps
//   while the sequencer waits in run; done loads the result. No new transaction is taken before that.
// A waiting result does not block the next transaction until its finish cycle.
// Synchronous active-high reset sets sequencer, counters, sticky flag, configuration and result valid.
`default_nettype none
module sparse_int_elementwise_arith_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sieac_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sieac_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [sieac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sieac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sieac_pkg::*;

   function automatic logic [MAG_W-1:0] magnitude(input logic [VALUE_W-1:0] v);
      magnitude = v[VALUE_W-1] ? (~v[MAG_W-1:0] + 1'b1) : v[MAG_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic                left_ff, left_in;
   logic                nabg_ff, nabg_in;
   logic                lac_ff, lac_in;
   logic [OFFSET_W-1:0] kept_count_ff, kept_count_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [VALUE_W-1:0]  x_ff, x_in;
   logic [VALUE_W-1:0]  y_ff, y_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                last_ff, last_in;

   unit_ctl_type        unit_ctl;
   unit_stat_type       unit_stat;
   logic [VALUE_W-1:0]  unit_hi;
   logic [MAG_W-1:0]    unit_lo;

   logic                accept;
   logic                iterative;
   logic [VALUE_W-1:0]  sv_w;
   logic [VALUE_W-1:0]  x_w;
   logic [VALUE_W-1:0]  y_w;

   logic                any_na;
   logic                sub_sel;
   logic [VALUE_W:0]    addsub;
   logic                addsub_ovf;
   logic [VALUE_W-1:0]  mag_w;
   logic                neg_sign;
   logic                rem_zero;
   logic [VALUE_W-1:0]  rem_trunc;
   logic [VALUE_W-1:0]  res;
   logic                ovf_now;
   logic [VALUE_W-1:0]  background;
   logic                keep;
   logic                commit;

   sieac_shift_unit u_shift (
      .clock (clock),
      .reset (reset),
      .ctl   (unit_ctl),
      .mag_a (magnitude(x_w)),
      .mag_b (magnitude(y_w)),
      .stat  (unit_stat),
      .hi    (unit_hi),
      .lo    (unit_lo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_ADD;
         left_ff       <= 1'b1;
         nabg_ff       <= 1'b0;
         lac_ff        <= 1'b0;
         kept_count_ff <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         left_ff       <= left_in;
         nabg_ff       <= nabg_in;
         lac_ff        <= lac_in;
         kept_count_ff <= kept_count_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff    <= rsp_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      offset_ff <= offset_in;
      last_ff   <= last_in;
   end

   // configuration writes
   always_comb begin
      op_in   = op_ff;
      left_in = left_ff;
      nabg_in = nabg_ff;
      lac_in  = lac_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OPERATION:      op_in   = op_type'(csr_wdata);
            CSR_SPARSE_ON_LEFT: left_in = csr_wdata[0];
            CSR_NA_BACKGROUND:  nabg_in = csr_wdata[0];
            CSR_LACUNAR_MODE:   lac_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // operand selection at accept
   always_comb begin
      sv_w = lac_ff ? VALUE_W'(1) : req_data.sparse_value;
      x_w  = left_ff ? sv_w : req_data.dense_value;
      y_w  = left_ff ? req_data.dense_value : sv_w;
   end

   // finish: sign handling, flooring and range checks
   always_comb begin
      any_na     = (x_ff == NA_VALUE) || (y_ff == NA_VALUE);
      sub_sel    = (op_ff == OP_SUB);
      addsub     = {x_ff[VALUE_W-1], x_ff} +
                   (sub_sel ? ~{y_ff[VALUE_W-1], y_ff} : {y_ff[VALUE_W-1], y_ff}) +
                   {{VALUE_W{1'b0}}, sub_sel};
      addsub_ovf = (addsub[VALUE_W] != addsub[VALUE_W-1]) ||
                   (addsub[VALUE_W-1:0] == NA_VALUE);
      mag_w      = {1'b0, unit_lo};
      neg_sign   = x_ff[VALUE_W-1] ^ y_ff[VALUE_W-1];
      rem_zero   = (unit_hi == '0);
      rem_trunc  = x_ff[VALUE_W-1] ? (~unit_hi + 1'b1) : unit_hi;
      res        = NA_VALUE;
      ovf_now    = 1'b0;
      if (!any_na) begin
         case (op_ff)
            OP_ADD, OP_SUB: begin
               if (addsub_ovf) begin
                  ovf_now = 1'b1;
               end else begin
                  res = addsub[VALUE_W-1:0];
               end
            end
            OP_MUL: begin
               if (unit_hi != '0) begin
                  ovf_now = 1'b1;
               end else begin
                  res = neg_sign ? (~mag_w + 1'b1) : mag_w;
               end
            end
            OP_MOD: begin
               if (y_ff != '0) begin
                  res = (!rem_zero && neg_sign) ? (rem_trunc + y_ff) : rem_trunc;
               end
            end
            OP_DIV: begin
               if (y_ff != '0) begin
                  if (!neg_sign) begin
                     res = mag_w;
                  end else if (rem_zero) begin
                     res = ~mag_w + 1'b1;
                  end else begin
                     res = ~mag_w;
                  end
               end
            end
            default: ;
         endcase
      end
      background = nabg_ff ? NA_VALUE : '0;
      keep       = (res != background);
   end

   // sequencer
   always_comb begin
      accept          = req_valid && req_ready;
      iterative       = (op_ff == OP_MUL) || (op_ff == OP_MOD) || (op_ff == OP_DIV);
      unit_ctl.start  = accept && iterative;
      unit_ctl.divide = (op_ff != OP_MUL);
      commit          = 1'b0;
      state_in        = state_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      offset_in       = offset_ff;
      last_in         = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in      = x_w;
               y_in      = y_w;
               offset_in = req_data.element_offset;
               last_in   = req_data.last_entry;
               state_in  = iterative ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (!unit_stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register and vector state
   always_comb begin
      kept_count_in = kept_count_ff;
      ovf_in        = ovf_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         ovf_in = ovf_ff | ovf_now;
         if (last_ff) begin
            kept_count_in = '0;
         end else if (keep) begin
            kept_count_in = kept_count_ff + 1'b1;
         end
         if (keep || last_ff) begin
            rsp_valid_in           = 1'b1;
            rsp_in.result_offset   = offset_ff;
            rsp_in.result_value    = res;
            rsp_in.output_position = kept_count_ff;
            rsp_in.kept            = keep;
            rsp_in.end_of_vector   = last_ff;
            rsp_in.overflow_seen   = ovf_ff | ovf_now;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_dropped_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.kept) |-> rsp_ff.end_of_vector)
      else $error("dropped result emitted without end of vector");

   a_kept_not_background: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kept) |->
      (rsp_ff.result_value != (nabg_ff ? NA_VALUE : '0)))
      else $error("kept result equals background");

   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without reset");

   a_unit_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      unit_stat.busy |-> (state_ff == ST_RUN))
      else $error("shift unit busy outside run state");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (commit && last_ff) |=> (kept_count_ff == '0))
      else $error("kept count not cleared after last entry");

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for the sparse integer element-wise arithmetic core, self-checking against a predictor.
`timescale 1ns / 1ps
module tb_top;
   import sieac_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam longint     NA_L         = 64'shFFFF_FFFF_8000_0000;
   localparam longint     MAX_L        = 64'sd2147483647;
   localparam int         DRAIN_CYCLES = 48;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         QUIET_LIMIT  = 5000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of configuration and state
   logic [2:0]            cfg_op;
   bit                    cfg_left;
   bit                    cfg_na_bg;
   bit                    cfg_lacunar;
   logic [OFFSET_W-1:0]   kept_in_vector;
   bit                    overflow_flag;

   rsp_type               expected_results[$];
   int                    send_idle_pct;
   int                    recv_idle_pct;
   bit                    hold_request;
   int                    mismatches;
   int                    n_accepted;
   int                    n_checked;
   int                    n_markers;
   int                    n_overflows;
   logic [7:0]            ops_seen;

   sparse_int_elementwise_arith_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint int_arith(input logic [2:0] op, input longint x, input longint y,
                                        output bit ovf);
      longint r;
      ovf = 1'b0;
      if (x == NA_L || y == NA_L) return NA_L;
      case (op)
         OP_ADD: r = x + y;
         OP_SUB: r = x - y;
         OP_MUL: r = x * y;
         OP_MOD: begin
            if (y == 0) return NA_L;
            r = x % y;
            if ((y > 0 && r < 0) || (y < 0 && r > 0)) r += y;
            return r;
         end
         OP_DIV: begin
            if (y == 0) return NA_L;
            r = x / y;
            if (((y > 0 && x < 0) || (y < 0 && x > 0)) && r * y != x) r--;
            return r;
         end
         default: return NA_L;
      endcase
      if (r <= NA_L || r > MAX_L) begin
         ovf = 1'b1;
         return NA_L;
      end
      return r;
   endfunction

   function automatic bit predict_result(input req_type r, output rsp_type want);
      longint sv;
      longint dv;
      longint res;
      longint bg;
      bit     ovf;
      bit     keep;
      sv = r.sparse_value;
      dv = r.dense_value;
      if (cfg_lacunar) sv = 1;
      if (cfg_left) res = int_arith(cfg_op, sv, dv, ovf);
      else res = int_arith(cfg_op, dv, sv, ovf);
      if (ovf) begin
         overflow_flag = 1'b1;
         n_overflows++;
      end
      bg = cfg_na_bg ? NA_L : 64'sd0;
      keep = (res != bg);
      want.result_offset   = r.element_offset;
      want.result_value    = res[31:0];
      want.output_position = kept_in_vector;
      want.kept            = keep;
      want.end_of_vector   = r.last_entry;
      want.overflow_seen   = overflow_flag;
      if (keep) kept_in_vector = kept_in_vector + 1'b1;
      if (r.last_entry) kept_in_vector = '0;
      return keep || r.last_entry;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9, 0))
         0, 1, 2: return $urandom;
         3, 4:    return 32'(int'($urandom_range(200, 0)) - 100);
         5:       return 32'sd0;
         6:       return NA_VALUE;
         7: begin
            case ($urandom_range(3, 0))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0001;
               2:       return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return 32'(int'($urandom_range(131071, 0)) - 65536);
      endcase
   endfunction

   function automatic req_type make_entry(input logic [OFFSET_W-1:0] off,
                                          input logic signed [VALUE_W-1:0] sv,
                                          input logic signed [VALUE_W-1:0] dv,
                                          input bit last);
      req_type e;
      e.element_offset = off;
      e.sparse_value   = sv;
      e.dense_value    = dv;
      e.last_entry     = last;
      return e;
   endfunction

   function automatic req_type random_entry(input bit last);
      logic signed [VALUE_W-1:0] sv;
      logic signed [VALUE_W-1:0] dv;
      sv = pick_value();
      case ($urandom_range(7, 0))
         0:       dv = sv;
         1:       dv = -sv;
         default: dv = pick_value();
      endcase
      return make_entry(31'($urandom), sv, dv, last || ($urandom_range(19, 0) == 0));
   endfunction

   task automatic send_entry(input req_type e);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= e;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] op, input bit left, input bit na_bg, input bit lac);
      csr_we    <= 1'b1;
      csr_index <= CSR_OPERATION;
      csr_wdata <= op;
      @(posedge clock);
      csr_index <= CSR_SPARSE_ON_LEFT;
      csr_wdata <= {2'($urandom_range(3, 0)), left};
      @(posedge clock);
      csr_index <= CSR_NA_BACKGROUND;
      csr_wdata <= {2'($urandom_range(3, 0)), na_bg};
      @(posedge clock);
      csr_index <= CSR_LACUNAR_MODE;
      csr_wdata <= {2'($urandom_range(3, 0)), lac};
      @(posedge clock);
      csr_we      <= 1'b0;
      cfg_op      = op;
      cfg_left    = left;
      cfg_na_bg   = na_bg;
      cfg_lacunar = lac;
   endtask

   task automatic test_reset_settings_add();
      send_entry(make_entry(31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, 1'b0));
      send_entry(make_entry(31'h0, 32'sh7FFF_FFFF, 32'sd1, 1'b0));
      send_entry(make_entry(31'h5, NA_VALUE, 32'sd5, 1'b0));
      send_entry(make_entry(31'h6, 32'sd3, -32'sd3, 1'b0));
      send_entry(make_entry(31'h7, -32'sd2147483647, -32'sd1, 1'b0));
      send_entry(make_entry(31'h9, 32'sd2, -32'sd2, 1'b1));
   endtask

   task automatic test_subtract_na_background();
      wait_until_drained();
      configure(OP_SUB, 1'b0, 1'b1, 1'b0);
      send_entry(make_entry(31'h10, 32'sd5, 32'sd9, 1'b0));
      send_entry(make_entry(31'h11, NA_VALUE, 32'sd1, 1'b1));
   endtask

   task automatic test_multiply_overflow();
      wait_until_drained();
      configure(OP_MUL, 1'b1, 1'b0, 1'b0);
      send_entry(make_entry(31'h20, 32'sd65536, 32'sd32768, 1'b0));
      send_entry(make_entry(31'h21, -32'sd65536, 32'sd32768, 1'b0));
      send_entry(make_entry(31'h22, -32'sd3, 32'sd7, 1'b0));
      send_entry(make_entry(31'h23, 32'sd0, NA_VALUE, 1'b1));
   endtask

   task automatic test_floored_modulo();
      wait_until_drained();
      configure(OP_MOD, 1'b1, 1'b0, 1'b0);
      send_entry(make_entry(31'h30, 32'sd7, -32'sd3, 1'b0));
      send_entry(make_entry(31'h31, -32'sd7, 32'sd3, 1'b0));
      send_entry(make_entry(31'h32, 32'sd5, 32'sd0, 1'b0));
      send_entry(make_entry(31'h33, -32'sd2147483647, 32'sd2147483647, 1'b1));
   endtask

   task automatic test_floored_division();
      wait_until_drained();
      configure(OP_DIV, 1'b0, 1'b0, 1'b0);
      send_entry(make_entry(31'h40, 32'sd3, -32'sd7, 1'b0));
      send_entry(make_entry(31'h41, -32'sd1, -32'sd2147483647, 1'b0));
      send_entry(make_entry(31'h42, 32'sd0, 32'sd5, 1'b0));
      send_entry(make_entry(31'h43, 32'sd2, 32'sd7, 1'b1));
   endtask

   task automatic test_unused_codes_and_lacunar();
      wait_until_drained();
      configure(OP_UNUSED_HI, 1'b1, 1'b0, 1'b1);
      send_entry(make_entry(31'h50, 32'sd12345, 32'sd6, 1'b1));
      wait_until_drained();
      configure(OP_ADD, 1'b1, 1'b0, 1'b1);
      send_entry(make_entry(31'h51, NA_VALUE, -32'sd1, 1'b0));
      send_entry(make_entry(31'h52, 32'sd0, 32'sh7FFF_FFFF, 1'b1));
      wait_until_drained();
      configure(OP_UNUSED_LO, 1'b0, 1'b1, 1'b0);
      send_entry(make_entry(31'h53, 32'sd1, 32'sd1, 1'b1));
      wait_until_drained();
   endtask

   task automatic test_random_traffic(input int n_items, input int tx_idle, input int rx_idle);
      int         done_items;
      int         vectors;
      int         vec_len;
      logic [2:0] op;
      send_idle_pct = tx_idle;
      recv_idle_pct = rx_idle;
      done_items    = 0;
      vectors       = 0;
      while (done_items < n_items) begin
         if (vectors % 6 == 0) begin
            wait_until_drained();
            if ($urandom_range(11, 0) == 0)
               op = 3'($urandom_range(int'(OP_UNUSED_HI), int'(OP_UNUSED_LO)));
            else
               op = 3'($urandom_range(int'(OP_DIV), int'(OP_ADD)));
            configure(op, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                      $urandom_range(4, 0) == 0);
         end
         vec_len = $urandom_range(12, 1);
         for (int k = 0; k < vec_len; k++) send_entry(random_entry(k == vec_len - 1));
         done_items += vec_len;
         vectors++;
      end
      wait_until_drained();
   endtask

   task automatic test_output_hold_off();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(OP_MUL, 1'b1, 1'b0, 1'b0);
      hold_request = 1'b1;
      for (int k = 0; k < 30; k++) send_entry(random_entry(k % 6 == 5));
      wait_until_drained();
   endtask

   // receiver: random ready, with a long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && req_ready) begin
         n_accepted++;
         ops_seen[cfg_op] = 1'b1;
         if (predict_result(req_data, want)) expected_results.push_back(want);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("error: unexpected result off=%h val=%h pos=%h kept=%b eov=%b ovf=%b",
                        rsp_data.result_offset, rsp_data.result_value,
                        rsp_data.output_position, rsp_data.kept, rsp_data.end_of_vector,
                        rsp_data.overflow_seen);
         end else begin
            want = expected_results.pop_front();
            n_checked++;
            if (!want.kept) n_markers++;
            if (rsp_data.result_offset !== want.result_offset ||
                rsp_data.result_value !== want.result_value ||
                rsp_data.output_position !== want.output_position ||
                rsp_data.kept !== want.kept ||
                rsp_data.end_of_vector !== want.end_of_vector ||
                rsp_data.overflow_seen !== want.overflow_seen) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"error: mismatch expected off=%h val=%h pos=%h kept=%b eov=%b ",
                            "ovf=%b got off=%h val=%h pos=%h kept=%b eov=%b ovf=%b"},
                           want.result_offset, want.result_value, want.output_position,
                           want.kept, want.end_of_vector, want.overflow_seen,
                           rsp_data.result_offset, rsp_data.result_value,
                           rsp_data.output_position, rsp_data.kept, rsp_data.end_of_vector,
                           rsp_data.overflow_seen);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("error: no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      cfg_op         = OP_ADD;
      cfg_left       = 1'b1;
      cfg_na_bg      = 1'b0;
      cfg_lacunar    = 1'b0;
      kept_in_vector = '0;
      overflow_flag  = 1'b0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_request   = 1'b0;
      mismatches     = 0;
      n_accepted     = 0;
      n_checked      = 0;
      n_markers      = 0;
      n_overflows    = 0;
      ops_seen       = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_settings_add();
      test_subtract_na_background();
      test_multiply_overflow();
      test_floored_modulo();
      test_floored_division();
      test_unused_codes_and_lacunar();
      test_random_traffic(630, 12, 86);
      test_random_traffic(630, 86, 12);
      test_output_hold_off();
      test_random_traffic(630, 0, 0);

      $display("summary: %0d entries accepted, %0d results checked, %0d of them end markers",
               n_accepted, n_checked, n_markers);
      $display("summary: %0d overflows, op codes seen %b, %0d-cycle output hold-off included",
               n_overflows, ops_seen, HOLD_CYCLES);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
